// ===== hdl/rec_pkg.sv =====
// Shared types, codes and defaults for the resource event coalescer.
// No dependencies; every other file in hdl/ uses this package.
package rec_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int ID_BITS         = 16;

    // Request and entry state codes
    localparam logic [1:0] REQ_PREFETCH = 2'd0;
    localparam logic [1:0] REQ_LOAD     = 2'd1;
    localparam logic [1:0] REQ_UNLOAD   = 2'd2;
    localparam logic [1:0] REQ_FLUSH    = 2'd3;
    localparam logic [1:0] ST_CANCEL    = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ID_BITS-1:0] resource_id;
    } rec_in_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [ID_BITS-1:0] resource_id_out;
        logic               empty_flush;
        logic               overflowed;
        logic               last;
    } rec_out_t;

    typedef struct packed {
        logic rd_en;
        logic a_we;
        logic b_we;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_LINK,
        S_APPEND,
        S_FEND
    } walk_state_t;

endpackage

// ===== hdl/rec_table.sv =====
// Entry storage: key/state memory and successor-pointer memory.
// Depends on rec_pkg (mem_ctl_t).
module rec_table #(
    parameter int TABLE_DEPTH = rec_pkg::DEF_TABLE_DEPTH,
    parameter int KW          = rec_pkg::DEF_ID_WIDTH,
    parameter int AW          = $clog2(rec_pkg::DEF_TABLE_DEPTH)
) (
    input  logic              aclk,
    input  rec_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     a_waddr,
    input  logic [KW-1:0]     a_wkey,
    input  logic [1:0]        a_wstate,
    input  logic [AW-1:0]     b_waddr,
    input  logic [AW-1:0]     b_wnext,
    output logic [KW-1:0]     rd_key,
    output logic [1:0]        rd_state,
    output logic [AW-1:0]     rd_next
);

    logic [KW+1:0] mem_a [TABLE_DEPTH];
    logic [AW-1:0] mem_b [TABLE_DEPTH];
    logic [KW+1:0] rd_a_reg;
    logic [AW-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (ctl.a_we) begin
            mem_a[a_waddr] <= {a_wkey, a_wstate};
        end
        if (ctl.rd_en) begin
            rd_a_reg <= mem_a[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.b_we) begin
            mem_b[b_waddr] <= b_wnext;
        end
        if (ctl.rd_en) begin
            rd_b_reg <= mem_b[rd_addr];
        end
    end

    assign rd_key   = rd_a_reg[KW+1:2];
    assign rd_state = rd_a_reg[1:0];
    assign rd_next  = rd_b_reg;

endmodule

// ===== hdl/rec_walker.sv =====
// List sequencer: walks the linked list to merge updates and to drain on flush.
// Depends on rec_pkg and drives the rec_table memories.
module rec_walker #(
    parameter int TABLE_DEPTH = rec_pkg::DEF_TABLE_DEPTH,
    parameter int KW          = rec_pkg::DEF_ID_WIDTH,
    parameter int AW          = $clog2(rec_pkg::DEF_TABLE_DEPTH),
    parameter int CW          = $clog2(rec_pkg::DEF_TABLE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rec_pkg::rec_in_t  s_data,
    input  logic              out_free,
    output logic              push,
    output rec_pkg::rec_out_t push_data,
    output rec_pkg::mem_ctl_t ctl,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     a_waddr,
    output logic [KW-1:0]     a_wkey,
    output logic [1:0]        a_wstate,
    output logic [AW-1:0]     b_waddr,
    output logic [AW-1:0]     b_wnext,
    input  logic [KW-1:0]     rd_key,
    input  logic [1:0]        rd_state,
    input  logic [AW-1:0]     rd_next
);

    rec_pkg::walk_state_t state_reg, state_next;
    logic [1:0]    req_reg, req_next;
    logic [KW-1:0] id_reg, id_next;
    logic [AW-1:0] p_reg, p_next, prev_reg, prev_next, slot_reg, slot_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] i_reg, i_next, count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [1:0]    pend_cmd_reg, pend_cmd_next;
    logic [KW-1:0] pend_id_reg, pend_id_next;

    logic          at_end, hit, live, do_move, changed;
    logic [1:0]    new_st;
    logic [AW-1:0] cnt_slot;

    assign at_end   = (i_reg == count_reg - CW'(1));
    assign hit      = (rd_key == id_reg);
    assign live     = (rd_state != rec_pkg::ST_CANCEL);
    assign cnt_slot = count_reg[AW-1:0];

    // merge rule for a known id
    always_comb begin
        new_st  = rd_state;
        do_move = 1'b0;
        if (req_reg == rd_state) begin
            new_st = rd_state;
        end else if (rd_state == rec_pkg::ST_CANCEL) begin
            new_st  = req_reg;
            do_move = 1'b1;
        end else if (req_reg == rec_pkg::REQ_UNLOAD) begin
            new_st = rec_pkg::ST_CANCEL;
        end else if (req_reg == rec_pkg::REQ_PREFETCH) begin
            if (rd_state == rec_pkg::REQ_UNLOAD) begin
                new_st  = rec_pkg::REQ_PREFETCH;
                do_move = 1'b1;
            end
        end else if (rd_state == rec_pkg::REQ_UNLOAD) begin
            new_st = rec_pkg::ST_CANCEL;
        end else begin
            new_st  = rec_pkg::REQ_LOAD;
            do_move = 1'b1;
        end
        changed = (new_st != rd_state);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rec_pkg::S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        id_reg       <= id_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        slot_reg     <= slot_next;
        i_reg        <= i_next;
        pend_cmd_reg <= pend_cmd_next;
        pend_id_reg  <= pend_id_next;
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        slot_next       = slot_reg;
        i_next          = i_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_id_next    = pend_id_reg;
        s_ready         = 1'b0;
        push            = 1'b0;
        push_data       = '0;
        ctl             = '0;
        rd_addr         = p_reg;
        a_waddr         = p_reg;
        a_wkey          = id_reg;
        a_wstate        = new_st;
        b_waddr         = prev_reg;
        b_wnext         = rd_next;

        case (state_reg)
            rec_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next  = s_data.req_type;
                    id_next   = s_data.resource_id[KW-1:0];
                    p_next    = head_reg;
                    i_next    = '0;
                    if (count_reg == '0) begin
                        state_next = (s_data.req_type == rec_pkg::REQ_FLUSH)
                                   ? rec_pkg::S_FEND : rec_pkg::S_APPEND;
                    end else begin
                        state_next = rec_pkg::S_RD;
                    end
                end
            end
            rec_pkg::S_RD: begin
                ctl.rd_en  = 1'b1;
                state_next = rec_pkg::S_CHK;
            end
            rec_pkg::S_CHK: begin
                if (req_reg == rec_pkg::REQ_FLUSH) begin
                    // hold while the previous live entry cannot be handed on
                    if (!(live && pend_valid_reg && !out_free)) begin
                        if (live && pend_valid_reg) begin
                            push                      = 1'b1;
                            push_data.command         = pend_cmd_reg;
                            push_data.resource_id_out = rec_pkg::ID_BITS'(pend_id_reg);
                            push_data.overflowed      = ovf_reg;
                        end
                        if (live) begin
                            pend_valid_next = 1'b1;
                            pend_cmd_next   = rd_state;
                            pend_id_next    = rd_key;
                        end
                        if (at_end) begin
                            state_next = rec_pkg::S_FEND;
                        end else begin
                            p_next     = rd_next;
                            i_next     = i_reg + CW'(1);
                            state_next = rec_pkg::S_RD;
                        end
                    end
                end else if (hit) begin
                    ctl.a_we   = changed;
                    state_next = rec_pkg::S_IDLE;
                    if (do_move && (p_reg != tail_reg)) begin
                        slot_next  = p_reg;
                        state_next = rec_pkg::S_LINK;
                        if (p_reg == head_reg) begin
                            head_next = rd_next;
                        end else begin
                            ctl.b_we = 1'b1;   // unlink: pred.next = slot.next
                        end
                    end
                end else if (at_end) begin
                    state_next = rec_pkg::S_APPEND;
                end else begin
                    prev_next  = p_reg;
                    p_next     = rd_next;
                    i_next     = i_reg + CW'(1);
                    state_next = rec_pkg::S_RD;
                end
            end
            rec_pkg::S_LINK: begin
                ctl.b_we   = 1'b1;
                b_waddr    = tail_reg;
                b_wnext    = slot_reg;
                tail_next  = slot_reg;
                state_next = rec_pkg::S_IDLE;
            end
            rec_pkg::S_APPEND: begin
                state_next = rec_pkg::S_IDLE;
                if (count_reg == CW'(TABLE_DEPTH)) begin
                    ovf_next = 1'b1;
                end else begin
                    ctl.a_we   = 1'b1;
                    a_waddr    = cnt_slot;
                    a_wstate   = req_reg;
                    b_waddr    = tail_reg;
                    b_wnext    = cnt_slot;
                    tail_next  = cnt_slot;
                    count_next = count_reg + CW'(1);
                    if (count_reg == '0) begin
                        head_next = cnt_slot;
                    end else begin
                        ctl.b_we = 1'b1;
                    end
                end
            end
            rec_pkg::S_FEND: begin
                if (out_free) begin
                    push                 = 1'b1;
                    push_data.overflowed = ovf_reg;
                    push_data.last       = 1'b1;
                    if (pend_valid_reg) begin
                        push_data.command         = pend_cmd_reg;
                        push_data.resource_id_out = rec_pkg::ID_BITS'(pend_id_reg);
                    end else begin
                        push_data.empty_flush = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    head_next       = '0;
                    tail_next       = '0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = rec_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rec_pkg::S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_read_check: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rec_pkg::S_RD |=> state_reg == rec_pkg::S_CHK)
        else $error("memory read not followed by check");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rec_pkg::S_FEND && out_free) |=> (count_reg == '0 && !ovf_reg))
        else $error("table not cleared after flush");

endmodule

// ===== hdl/resource_event_coalescer.sv =====
// Top level of the resource event coalescer: sequencer, entry memories and
// the result output register. Depends on rec_pkg, rec_table and rec_walker.
//
// Usage: requests enter on s_valid/s_ready/s_data (req_type, resource_id).
// Prefetch, load and unload requests merge into a linked table of at most
// TABLE_DEPTH entries and produce no result. A flush request drains the live
// entries in list order on m_valid/m_ready/m_data, marks the final one with
// last, reports the sticky overflow flag on every result and then empties
// the table; with nothing live it emits one result with empty_flush set.
// Timing: the sequencer walks the list through a memory with a registered
// read, so each entry read passes through S_RD and then S_CHK. An update
// reads entries up to the match, or all of them on a miss, and may then go
// to S_APPEND for an append attempt or S_LINK for a move to the tail. A flush
// reads every entry and ends in S_FEND, holding if the receiver stalls.
// Stalls: one result register sits on the output; the block takes the next
// request as soon as a flush has queued its last result, and a drain holds
// in place while that register is full.
// Reset (aresetn low, synchronous) empties the table and clears the flag;
// the memories need no clearing pass.
module resource_event_coalescer #(
    parameter int TABLE_DEPTH = rec_pkg::DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = rec_pkg::DEF_ID_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rec_pkg::rec_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rec_pkg::rec_out_t m_data
);

    // stored key width: ids are at most ID_BITS wide
    localparam int KW = (ID_WIDTH < rec_pkg::ID_BITS) ? ID_WIDTH : rec_pkg::ID_BITS;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    rec_pkg::mem_ctl_t ctl;
    rec_pkg::rec_out_t push_data;
    logic              push, out_free;
    logic [AW-1:0]     rd_addr, a_waddr, b_waddr, b_wnext, rd_next;
    logic [KW-1:0]     a_wkey, rd_key;
    logic [1:0]        a_wstate, rd_state;

    logic              m_valid_reg, m_valid_next;
    rec_pkg::rec_out_t m_data_reg, m_data_next;

    // output register is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    rec_walker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KW(KW),
        .AW(AW),
        .CW(CW)
    ) u_walker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .out_free(out_free),
        .push(push),
        .push_data(push_data),
        .ctl(ctl),
        .rd_addr(rd_addr),
        .a_waddr(a_waddr),
        .a_wkey(a_wkey),
        .a_wstate(a_wstate),
        .b_waddr(b_waddr),
        .b_wnext(b_wnext),
        .rd_key(rd_key),
        .rd_state(rd_state),
        .rd_next(rd_next)
    );

    rec_table #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KW(KW),
        .AW(AW)
    ) u_table (
        .aclk(aclk),
        .ctl(ctl),
        .rd_addr(rd_addr),
        .a_waddr(a_waddr),
        .a_wkey(a_wkey),
        .a_wstate(a_wstate),
        .b_waddr(b_waddr),
        .b_wnext(b_wnext),
        .rd_key(rd_key),
        .rd_state(rd_state),
        .rd_next(rd_next)
    );

    // load a new result, or drop the valid once the current one is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = push_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== bench/tb_resource_event_coalescer.sv =====
// Self-checking bench for resource_event_coalescer: drives prefetch, load,
// unload and flush requests, predicts every flush result and compares them.
// Depends on rec_pkg and the RTL under hdl/.
module tb_resource_event_coalescer;

    localparam int DEPTH = rec_pkg::DEF_TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT = 20000;

    // Scoreboard: private copy of the coalescing table plus the queue of
    // flush results still owed by the block.
    class coalesce_scoreboard;
        logic [15:0]       slot_key [DEPTH];
        logic [1:0]        slot_state [DEPTH];
        int                slot_next [DEPTH];
        bit                slot_used [DEPTH];
        int                head, tail, count;
        bit                ovf;
        rec_pkg::rec_out_t pending [$];
        int                errors;

        function void clear_table();
            for (int i = 0; i < DEPTH; i++) begin
                slot_used[i] = 0;
                slot_next[i] = 0;
            end
            head = 0;
            tail = 0;
            count = 0;
        endfunction

        function void reset_all();
            clear_table();
            ovf = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void move_tail(int s);
            int p;
            if (s == tail) return;
            if (s == head) begin
                head = slot_next[s];
            end else begin
                p = head;
                for (int n = 0; n < DEPTH; n++) begin
                    if (slot_next[p] == s) break;
                    p = slot_next[p];
                end
                slot_next[p] = slot_next[s];
            end
            slot_next[tail] = s;
            tail = s;
        endfunction

        function void merge(logic [1:0] r, logic [15:0] id);
            int s;
            logic [1:0] st;
            s = -1;
            for (int i = 0; i < DEPTH; i++)
                if (s < 0 && slot_used[i] && slot_key[i] == id) s = i;
            if (s < 0) begin
                for (int i = 0; i < DEPTH; i++)
                    if (s < 0 && !slot_used[i]) s = i;
                if (s < 0) begin
                    ovf = 1;
                    return;
                end
                slot_used[s] = 1;
                slot_key[s] = id;
                slot_state[s] = r;
                slot_next[s] = 0;
                if (count == 0) head = s;
                else slot_next[tail] = s;
                tail = s;
                count++;
                return;
            end
            st = slot_state[s];
            if (r == st) return;
            if (st == rec_pkg::ST_CANCEL) begin
                slot_state[s] = r;
                move_tail(s);
            end else if (r == rec_pkg::REQ_UNLOAD) begin
                slot_state[s] = rec_pkg::ST_CANCEL;
            end else if (r == rec_pkg::REQ_PREFETCH) begin
                if (st == rec_pkg::REQ_UNLOAD) begin
                    slot_state[s] = rec_pkg::REQ_PREFETCH;
                    move_tail(s);
                end
            end else if (st == rec_pkg::REQ_UNLOAD) begin
                slot_state[s] = rec_pkg::ST_CANCEL;
            end else begin
                slot_state[s] = rec_pkg::REQ_LOAD;
                move_tail(s);
            end
        endfunction

        // Note an accepted request; a flush queues its drained entries.
        function void note_request(rec_pkg::rec_in_t req);
            int p, n;
            rec_pkg::rec_out_t r;
            if (req.req_type != rec_pkg::REQ_FLUSH) begin
                merge(req.req_type, req.resource_id);
                return;
            end
            p = head;
            n = 0;
            for (int i = 0; i < count; i++) begin
                if (slot_state[p] != rec_pkg::ST_CANCEL) begin
                    r.command = slot_state[p];
                    r.resource_id_out = slot_key[p];
                    r.empty_flush = 0;
                    r.overflowed = ovf;
                    r.last = 0;
                    pending.push_back(r);
                    n++;
                end
                p = slot_next[p];
            end
            if (n == 0) begin
                r = '0;
                r.empty_flush = 1;
                r.overflowed = ovf;
                r.last = 1;
                pending.push_back(r);
            end else begin
                pending[pending.size()-1].last = 1;
            end
            clear_table();
            ovf = 0;
        endfunction

        function void check_result(rec_pkg::rec_out_t got);
            rec_pkg::rec_out_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p", $realtime, got);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got !== exp) begin
                $display("%0t: mismatch expected %p actual %p", $realtime, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    rec_pkg::rec_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 0;
    rec_pkg::rec_out_t m_data;

    coalesce_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  stuck_cycles;
    bit  timed_out = 0;
    logic [15:0] id_pool [8];

    resource_event_coalescer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Monitor: note requests and check results at each rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Receiver stall pattern, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Send one request: optional idle gap, then hold valid until accepted.
    task automatic send_request(logic [1:0] kind, logic [15:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{req_type: kind, resource_id: id};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly a small pool of ids so merges happen; sometimes any id.
    task automatic send_random(int flush_pct);
        logic [1:0]  kind;
        logic [15:0] id;
        if ($urandom_range(99) < flush_pct) kind = rec_pkg::REQ_FLUSH;
        else kind = 2'($urandom_range(2));
        if ($urandom_range(3) != 0) id = id_pool[$urandom_range(7)];
        else id = 16'($urandom);
        send_request(kind, id);
    endtask

    initial begin
        sb = new();
        sb.reset_all();
        send_idle_pct = 17;
        recv_idle_pct = 51;
        for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty flush, extremes, every merge rule, overflow.
        send_request(rec_pkg::REQ_FLUSH, 16'h0000);
        send_request(rec_pkg::REQ_PREFETCH, 16'h0000);
        send_request(rec_pkg::REQ_LOAD, 16'hFFFF);
        send_request(rec_pkg::REQ_UNLOAD, 16'h5A5A);
        send_request(rec_pkg::REQ_PREFETCH, 16'h0000);   // equal state: drop
        send_request(rec_pkg::REQ_PREFETCH, 16'h5A5A);   // unload to prefetch, move
        send_request(rec_pkg::REQ_LOAD, 16'h0000);       // prefetch upgraded, move
        send_request(rec_pkg::REQ_UNLOAD, 16'hFFFF);     // cancel in place
        send_request(rec_pkg::REQ_PREFETCH, 16'hFFFF);   // reactivate, move
        send_request(rec_pkg::REQ_UNLOAD, 16'hA5A5);
        send_request(rec_pkg::REQ_LOAD, 16'hA5A5);       // load cancels unload
        send_request(rec_pkg::REQ_PREFETCH, 16'h0000);   // prefetch over load: drop
        send_request(rec_pkg::REQ_FLUSH, 16'hFFFF);
        send_request(rec_pkg::REQ_UNLOAD, 16'h1234);
        send_request(rec_pkg::REQ_UNLOAD, 16'h1234);
        send_request(rec_pkg::REQ_PREFETCH, 16'h1234);
        send_request(rec_pkg::REQ_UNLOAD, 16'h1234);     // all cancelled
        send_request(rec_pkg::REQ_FLUSH, 16'h0001);
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(2'(i % 3), 16'(16'h8000 + i));
        send_request(rec_pkg::REQ_FLUSH, 16'h0000);

        // Random: three idle phases of 105 random requests and a flush each.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 51;
                recv_idle_pct = 17;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 105; i++) send_random(ph == 2 ? 4 : 8);
            send_request(rec_pkg::REQ_FLUSH, 16'($urandom));
        end
        s_valid <= 0;

        while (sb.pending.size() != 0 && !timed_out) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (!timed_out) begin
            if (sb.errors == 0) $display("Test completed successfully");
            else $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stuck_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
